// File: rtl/tme_pkg.sv
// Shared constants, codes and handshake structs of the typed mailbox engine.
package tme_pkg;

   localparam int PROCS       = 8;
   localparam int SLOTS       = 16;
   localparam int PID_W       = (PROCS > 1) ? $clog2(PROCS) : 1;
   localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W       = $clog2(SLOTS + 1);
   localparam int ENTRIES     = PROCS * SLOTS;
   localparam int ADDR_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int SLOT_DATA_W = 48;
   localparam int REQ_DATA_W  = 88;
   localparam int RSP_DATA_W  = 96;

   localparam logic [7:0] WILDCARD = 8'd42;

   typedef enum logic [1:0] {
      MODE_CLEAR = 2'd0,
      MODE_SEND  = 2'd1,
      MODE_READ  = 2'd2,
      MODE_RSVD  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      STAT_STORED    = 3'd0,
      STAT_DELIVERED = 3'd1,
      STAT_READ      = 3'd2,
      STAT_BLOCKED   = 3'd3,
      STAT_FULL      = 3'd4,
      STAT_BADTYPE   = 3'd5,
      STAT_BADPID    = 3'd6,
      STAT_CLEARED   = 3'd7
   } status_type;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic capture;
      logic decide;
      logic scan;
      logic load;
   } cmd_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic need_scan;
      logic scan_done;
      logic out_free;
   } sts_type;

   // One stored message.
   typedef struct packed {
      logic [7:0]  sender;
      logic [7:0]  kind;
      logic [31:0] word;
   } slot_type;

endpackage

// File: rtl/tme_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tme_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/tme_ctrl.sv
// Sequencer of the typed mailbox engine: accept, decide, slot scan, result hand-off.
module tme_ctrl
   import tme_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_DECIDE = 4'b0010,
      S_SCAN   = 4'b0100,
      S_DONE   = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_tready  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
            if (req_tvalid) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = sts.need_scan ? S_SCAN : S_DONE;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            cmd.load = sts.out_free;
            if (sts.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/tme_datapath.sv
// Datapath of the typed mailbox engine: request registers, slot store, wait types, results.
module tme_datapath
   import tme_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output sts_type               sts,
   input  logic [1:0]            req_tuser,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [2:0]            rsp_tuser,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   typedef struct packed {
      logic [4:0]         pad;
      logic signed [31:0] ticks;
      logic               block;
      logic               kill;
      logic               wake;
      logic [31:0]        word;
      logic [7:0]         kind;
      logic [7:0]         receiver;
      logic [7:0]         sender;
   } res_type;

   // Captured request.
   mode_type           mode_ff, mode_in;
   logic [7:0]         tgt_ff, tgt_in;
   logic [7:0]         snd_ff, snd_in;
   logic [7:0]         typ_ff, typ_in;
   logic [31:0]        word_ff, word_in;
   logic signed [31:0] ticks_ff, ticks_in;

   // Mailbox state.
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [7:0]         wait_ff [PROCS];
   logic [7:0]         wait_in [PROCS];

   // Scan control.
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               chk_ff, chk_in;
   logic [SLOT_W-1:0]  chk_idx_ff, chk_idx_in;
   logic               chk_vld_ff, chk_vld_in;

   // Result and output stage.
   status_type         res_status_ff, res_status_in;
   res_type            res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   res_type            rsp_data_ff, rsp_data_in;

   logic [PID_W-1:0]   pid;
   logic               bad_req;
   logic               is_clear;
   logic               is_send;
   logic               bad_type;
   logic [7:0]         wait_cur;
   logic               wait_hit;
   logic [ADDR_W-1:0]  base;
   logic [ADDR_W-1:0]  scan_addr;
   logic [ADDR_W-1:0]  chk_addr;
   logic               free_hit;
   logic               send_last;
   logic               issue;
   logic               read_hit;
   logic               read_end;
   logic               ram_wr_en;
   slot_type           ram_wr_data;
   slot_type           ram_rd_data;

   assign pid      = tgt_ff[PID_W-1:0];
   assign bad_req  = ({1'b0, tgt_ff} >= 9'(PROCS)) || (mode_ff == MODE_RSVD);
   assign is_clear = (mode_ff == MODE_CLEAR);
   assign is_send  = (mode_ff == MODE_SEND);
   assign bad_type = (typ_ff == 8'd0);
   assign wait_cur = wait_ff[pid];
   assign wait_hit = is_send && ((wait_cur == WILDCARD) || (wait_cur == typ_ff));

   assign base      = ADDR_W'(pid) * ADDR_W'(SLOTS);
   assign scan_addr = base + ADDR_W'(cnt_ff[SLOT_W-1:0]);
   assign chk_addr  = base + ADDR_W'(chk_idx_ff);

   assign free_hit  = !valid_ff[scan_addr];
   assign send_last = (cnt_ff == CNT_W'(SLOTS - 1));
   assign issue     = (cnt_ff < CNT_W'(SLOTS));
   assign read_hit  = chk_ff && chk_vld_ff
                      && ((typ_ff == WILDCARD) || (ram_rd_data.kind == typ_ff));
   assign read_end  = chk_ff && (chk_idx_ff == SLOT_W'(SLOTS - 1));

   assign sts.need_scan = !bad_req && !is_clear && !bad_type && !wait_hit;
   assign sts.scan_done = cmd.scan && (is_send ? (free_hit || send_last)
                                               : (read_hit || read_end));
   assign sts.out_free  = !rsp_valid_ff || rsp_tready;

   assign ram_wr_en          = cmd.scan && is_send && free_hit;
   assign ram_wr_data.sender = snd_ff;
   assign ram_wr_data.kind   = typ_ff;
   assign ram_wr_data.word   = word_ff;

   tme_ram #(
      .WIDTH (SLOT_DATA_W),
      .DEPTH (ENTRIES)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (scan_addr),
      .wr_data (ram_wr_data),
      .rd_addr (scan_addr),
      .rd_data (ram_rd_data)
   );

   // Request capture and scan counters.
   always_comb begin
      mode_in    = mode_ff;
      tgt_in     = tgt_ff;
      snd_in     = snd_ff;
      typ_in     = typ_ff;
      word_in    = word_ff;
      ticks_in   = ticks_ff;
      cnt_in     = cnt_ff;
      chk_in     = chk_ff;
      chk_idx_in = chk_idx_ff;
      chk_vld_in = chk_vld_ff;
      if (cmd.capture) begin
         mode_in  = mode_type'(req_tuser);
         tgt_in   = req_tdata[7:0];
         snd_in   = req_tdata[15:8];
         typ_in   = req_tdata[23:16];
         word_in  = req_tdata[55:24];
         ticks_in = req_tdata[87:56];
         cnt_in   = '0;
         chk_in   = 1'b0;
      end else if (cmd.scan) begin
         if (is_send || issue) begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
         chk_in     = !is_send && issue;
         chk_idx_in = cnt_ff[SLOT_W-1:0];
         chk_vld_in = valid_ff[scan_addr];
      end
   end

   // Slot occupancy and waiting types.
   always_comb begin
      valid_in = valid_ff;
      wait_in  = wait_ff;
      if (cmd.decide && !bad_req) begin
         if (is_clear) begin
            for (int e = 0; e < ENTRIES; e++) begin
               if ((e / SLOTS) == int'(tgt_ff)) begin
                  valid_in[e] = 1'b0;
               end
            end
            wait_in[pid] = 8'd0;
         end else if (!bad_type && wait_hit) begin
            wait_in[pid] = 8'd0;
         end
      end
      if (cmd.scan) begin
         if (is_send) begin
            if (free_hit) begin
               valid_in[scan_addr] = 1'b1;
            end
         end else if (read_hit) begin
            valid_in[chk_addr] = 1'b0;
         end else if (read_end) begin
            wait_in[pid] = typ_ff;
         end
      end
   end

   // Result of the request in flight.
   always_comb begin
      res_status_in = res_status_ff;
      res_in        = res_ff;
      if (cmd.decide) begin
         res_in = '0;
         if (bad_req) begin
            res_status_in = STAT_BADPID;
         end else if (is_clear) begin
            res_status_in = STAT_CLEARED;
         end else if (bad_type) begin
            res_status_in = STAT_BADTYPE;
         end else if (wait_hit) begin
            res_status_in   = STAT_DELIVERED;
            res_in.sender   = snd_ff;
            res_in.receiver = tgt_ff;
            res_in.kind     = typ_ff;
            res_in.word     = word_ff;
            res_in.wake     = 1'b1;
         end
      end else if (sts.scan_done) begin
         res_in = '0;
         if (is_send) begin
            if (free_hit) begin
               res_status_in = STAT_STORED;
            end else begin
               res_status_in = STAT_FULL;
               res_in.kill   = 1'b1;
            end
         end else if (read_hit) begin
            res_status_in   = STAT_READ;
            res_in.sender   = ram_rd_data.sender;
            res_in.receiver = tgt_ff;
            res_in.kind     = ram_rd_data.kind;
            res_in.word     = ram_rd_data.word;
         end else begin
            res_status_in = STAT_BLOCKED;
            res_in.block  = 1'b1;
            res_in.ticks  = ticks_ff;
         end
      end
   end

   // Output register.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      if (cmd.load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_data_in   = res_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         wait_ff      <= '{default: '0};
         chk_ff       <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         wait_ff      <= wait_in;
         chk_ff       <= chk_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      tgt_ff        <= tgt_in;
      snd_ff        <= snd_in;
      typ_ff        <= typ_in;
      word_ff       <= word_in;
      ticks_ff      <= ticks_in;
      chk_idx_ff    <= chk_idx_in;
      chk_vld_ff    <= chk_vld_in;
      res_status_ff <= res_status_in;
      res_ff        <= res_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: rtl/typed_mailbox_engine_top.sv
// Top level of the typed mailbox engine: sequencer plus mailbox datapath.
//
// Each request on the req_ channel is a mailbox operation chosen by req_tuser:
// clear a process's mailbox, send a typed message to a process, or read from a
// process's mailbox by type (42 acts as the read wildcard). Every request
// produces exactly one response on the rsp_ channel; rsp_tuser carries the
// outcome code and rsp_tdata the message, the wake, kill and block flags and
// the echoed timeout, with fields that do not apply driven to zero.
// Requests are taken one at a time. Clear, rejected requests and direct
// delivery to a waiting receiver skip the slot scan and go from the decide
// step straight to the result hand-off. A send scans the slot occupancy bits
// one slot per cycle and a read scans the slot memory one slot per cycle
// through its registered read port, stopping early at a usable slot.
// The next request is accepted in the cycle after the response is loaded.
// Reset empties every mailbox and clears every waiting type at once, through
// per-slot occupancy flops, so no clearing pass is needed.
// When the receiver stalls, the response holds in the output register and the
// block finishes at most one more request before it waits for that register.
module typed_mailbox_engine_top
   import tme_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request channel.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tuser: mode [1:0].
   input  logic [1:0]            req_tuser,
   // tdata: target_pid [7:0], sender_pid [15:8], msg_type [23:16],
   // payload [55:24], sleep_ticks [87:56].
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // Response channel.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // tuser: status [2:0].
   output logic [2:0]            rsp_tuser,
   // tdata: msg_sender [7:0], msg_receiver [15:8], msg_kind [23:16],
   // msg_word [55:24], wake_receiver [56], kill_sender [57],
   // block_reader [58], block_ticks [90:59], zero fill [95:91].
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   cmd_type cmd;
   sts_type sts;

   tme_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   tme_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
